// ===== rtl/ean13_pkg.sv =====
`timescale 1ns / 1ps

package ean13_pkg;

    localparam int unsigned NUM_DIGITS  = 12;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CODE_W      = 7;
    localparam int unsigned WEIGHT_W    = 5;
    localparam int unsigned SUM_W       = 8;
    localparam int unsigned NUM_LEFT    = 6;
    localparam int unsigned NUM_RIGHT   = 5;
    localparam int unsigned LEFT_W      = NUM_LEFT * CODE_W;
    localparam int unsigned RIGHT_W     = NUM_RIGHT * CODE_W;
    localparam int unsigned FIRST_RIGHT = 7;
    localparam int unsigned PARITY_W    = 6;
    localparam logic [PARITY_W-1:0] PARITY_RESET = 6'd38;

    localparam logic [2:0] EDGE_GUARD   = 3'b101;
    localparam logic [4:0] CENTER_GUARD = 5'b01010;

    typedef struct packed {
        logic triple;
        logic right;
        logic use_g;
    } lane_ctl_t;

    typedef struct packed {
        logic                err;
        logic [WEIGHT_W-1:0] weighted;
        logic [CODE_W-1:0]   code;
    } lane_res_t;

    function automatic logic [CODE_W-1:0] code_l(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 7'h0D;
            4'd1:    c = 7'h19;
            4'd2:    c = 7'h13;
            4'd3:    c = 7'h3D;
            4'd4:    c = 7'h23;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h2F;
            4'd7:    c = 7'h3B;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h0B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] code_g(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 7'h27;
            4'd1:    c = 7'h33;
            4'd2:    c = 7'h1B;
            4'd3:    c = 7'h21;
            4'd4:    c = 7'h1D;
            4'd5:    c = 7'h39;
            4'd6:    c = 7'h05;
            4'd7:    c = 7'h11;
            4'd8:    c = 7'h09;
            4'd9:    c = 7'h17;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] code_r(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 7'h72;
            4'd1:    c = 7'h66;
            4'd2:    c = 7'h6C;
            4'd3:    c = 7'h42;
            4'd4:    c = 7'h5C;
            4'd5:    c = 7'h4E;
            4'd6:    c = 7'h50;
            4'd7:    c = 7'h44;
            4'd8:    c = 7'h48;
            4'd9:    c = 7'h74;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ean13_lane.sv =====
`timescale 1ns / 1ps

module ean13_lane
(
    input  logic [ean13_pkg::DIGIT_W-1:0] digit,
    input  ean13_pkg::lane_ctl_t          ctl,
    output ean13_pkg::lane_res_t          res
);

    logic [ean13_pkg::WEIGHT_W-1:0] single;
    logic [ean13_pkg::WEIGHT_W-1:0] tripled;

    always_comb
    begin
        single  = {1'b0, digit};
        tripled = single + {digit, 1'b0};
        res.err = (digit > 4'd9);
        res.weighted = ctl.triple ? tripled : single;
        if (ctl.right)
        begin
            res.code = ean13_pkg::code_r(digit);
        end
        else if (ctl.use_g)
        begin
            res.code = ean13_pkg::code_g(digit);
        end
        else
        begin
            res.code = ean13_pkg::code_l(digit);
        end
    end

endmodule

// ===== rtl/ean13_merge.sv =====
`timescale 1ns / 1ps

module ean13_merge
(
    input  logic [ean13_pkg::SUM_W-1:0]   sum,
    input  logic                          err,
    input  logic [ean13_pkg::LEFT_W-1:0]  left_codes,
    input  logic [ean13_pkg::RIGHT_W-1:0] right_codes,
    output logic [30:0]                   pattern_high,
    output logic [63:0]                   pattern_low,
    output logic [3:0]                    check_digit
);

    logic [18:0] prod;
    logic [7:0]  quot;
    logic [7:0]  rem;
    logic [3:0]  chk;
    logic [94:0] full;

    // The sum stays below 256, where multiplying by 205 and dropping
    // eleven bits gives the exact quotient by ten.
    always_comb
    begin
        prod = 19'(sum) * 19'd205;
        quot = 8'(prod >> 11);
        rem  = sum - 8'(quot * 8'd10);
        chk  = (rem == 8'd0) ? 4'd0 : 4'(8'd10 - rem);
        full = {ean13_pkg::EDGE_GUARD, left_codes, ean13_pkg::CENTER_GUARD,
                right_codes, ean13_pkg::code_r(chk), ean13_pkg::EDGE_GUARD};
        if (err)
        begin
            pattern_high = '0;
            pattern_low  = '0;
            check_digit  = '0;
        end
        else
        begin
            pattern_high = full[94:64];
            pattern_low  = full[63:0];
            check_digit  = chk;
        end
    end

endmodule

// ===== rtl/ean13_barcode_encoder.sv =====
// An accepted digit word passes the lane, sum and result registers in turn.
// Throughput: one word per cycle while no result stalls; twelve digit lanes
// and a three-stage pipeline. A stalled result holds the pipeline; input is
// taken whenever a stage frees up. Reset (rst_n low, asynchronous) empties
// the pipeline and sets the parity register to 38.
`timescale 1ns / 1ps

module ean13_barcode_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        digits_valid,
    output logic        digits_stall,
    input  logic [47:0] digits_bcd,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [30:0] pattern_high,
    output logic [63:0] pattern_low,
    output logic [3:0]  check_digit,
    output logic        digit_error
);

    localparam int unsigned ND = ean13_pkg::NUM_DIGITS;
    localparam int unsigned CW = ean13_pkg::CODE_W;

    logic [ean13_pkg::PARITY_W-1:0] parity_reg;

    ean13_pkg::lane_res_t lane_res [ND];

    logic                           s1_valid_reg;
    logic                           s1_err_reg;
    logic [ean13_pkg::WEIGHT_W-1:0] s1_weight_reg [ND];
    logic [ean13_pkg::LEFT_W-1:0]   s1_left_reg;
    logic [ean13_pkg::RIGHT_W-1:0]  s1_right_reg;

    logic                           s2_valid_reg;
    logic                           s2_err_reg;
    logic [ean13_pkg::SUM_W-1:0]    s2_sum_reg;
    logic [ean13_pkg::LEFT_W-1:0]   s2_left_reg;
    logic [ean13_pkg::RIGHT_W-1:0]  s2_right_reg;

    logic                           result_valid_reg;
    logic [30:0]                    pattern_high_reg;
    logic [63:0]                    pattern_low_reg;
    logic [3:0]                     check_digit_reg;
    logic                           digit_error_reg;

    logic                           lane_err;
    logic [ean13_pkg::LEFT_W-1:0]   left_codes;
    logic [ean13_pkg::RIGHT_W-1:0]  right_codes;
    logic [ean13_pkg::SUM_W-1:0]    pair_sum [6];
    logic [ean13_pkg::SUM_W-1:0]    quad_sum [3];
    logic [ean13_pkg::SUM_W-1:0]    sum_next;
    logic [30:0]                    pattern_high_next;
    logic [63:0]                    pattern_low_next;
    logic [3:0]                     check_digit_next;

    logic adv_out;
    logic adv2;
    logic adv1;

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++)
        begin : g_lane
            ean13_pkg::lane_ctl_t ctl;
            if (gi >= 1 && gi <= ean13_pkg::NUM_LEFT)
            begin : g_left
                assign ctl.use_g = parity_reg[gi-1];
            end
            else
            begin : g_other
                assign ctl.use_g = 1'b0;
            end
            assign ctl.triple = ((gi % 2) == 1);
            assign ctl.right  = (gi >= ean13_pkg::FIRST_RIGHT);

            ean13_lane u_lane
            (
                .digit (digits_bcd[47-4*gi -: 4]),
                .ctl   (ctl),
                .res   (lane_res[gi])
            );
        end
    endgenerate

    always_comb
    begin
        lane_err    = 1'b0;
        left_codes  = '0;
        right_codes = '0;
        for (int i = 0; i < ND; i++)
        begin
            lane_err = lane_err | lane_res[i].err;
        end
        for (int k = 0; k < ean13_pkg::NUM_LEFT; k++)
        begin
            left_codes[ean13_pkg::LEFT_W-1-CW*k -: CW] = lane_res[k+1].code;
        end
        for (int k = 0; k < ean13_pkg::NUM_RIGHT; k++)
        begin
            right_codes[ean13_pkg::RIGHT_W-1-CW*k -: CW] =
                lane_res[k+ean13_pkg::FIRST_RIGHT].code;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pair_sum[k] = ean13_pkg::SUM_W'(s1_weight_reg[2*k])
                        + ean13_pkg::SUM_W'(s1_weight_reg[2*k+1]);
        end
        for (int k = 0; k < 3; k++)
        begin
            quad_sum[k] = pair_sum[2*k] + pair_sum[2*k+1];
        end
        sum_next = quad_sum[0] + quad_sum[1] + quad_sum[2];
    end

    ean13_merge u_merge
    (
        .sum          (s2_sum_reg),
        .err          (s2_err_reg),
        .left_codes   (s2_left_reg),
        .right_codes  (s2_right_reg),
        .pattern_high (pattern_high_next),
        .pattern_low  (pattern_low_next),
        .check_digit  (check_digit_next)
    );

    assign adv_out      = !result_valid_reg || !result_stall;
    assign adv2         = !s2_valid_reg || adv_out;
    assign adv1         = !s1_valid_reg || adv2;
    assign digits_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg       <= ean13_pkg::PARITY_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                parity_reg <= cfg_data;
            end
            if (adv1)
            begin
                s1_valid_reg <= digits_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && digits_valid)
        begin
            s1_err_reg   <= lane_err;
            s1_left_reg  <= left_codes;
            s1_right_reg <= right_codes;
            for (int i = 0; i < ND; i++)
            begin
                s1_weight_reg[i] <= lane_res[i].weighted;
            end
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_err_reg   <= s1_err_reg;
            s2_sum_reg   <= sum_next;
            s2_left_reg  <= s1_left_reg;
            s2_right_reg <= s1_right_reg;
        end
        if (adv_out && s2_valid_reg)
        begin
            pattern_high_reg <= pattern_high_next;
            pattern_low_reg  <= pattern_low_next;
            check_digit_reg  <= check_digit_next;
            digit_error_reg  <= s2_err_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign pattern_high = pattern_high_reg;
    assign pattern_low  = pattern_low_reg;
    assign check_digit  = check_digit_reg;
    assign digit_error  = digit_error_reg;

    a_bad_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && digit_error |->
            pattern_high == 31'd0 && pattern_low == 64'd0 && check_digit == 4'd0)
        else $error("bad digit word carries a nonzero pattern");

    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> check_digit <= 4'd9)
        else $error("check digit out of range");

    a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !adv2 |=> s2_valid_reg && $stable(s2_sum_reg))
        else $error("middle stage lost a word under stall");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        digits_valid && !digits_stall |=> s1_valid_reg)
        else $error("accepted word did not enter the lane stage");

endmodule
